[rtl/core/sbs_pkg.sv]
package sbs_pkg;

	// Block dimensions.
	localparam int BINS        = 256;
	localparam int WINDOW      = 512;
	localparam int SAMPLE_BITS = 16;

	localparam int BIN_BITS = $clog2(BINS);
	localparam int WIN_BITS = $clog2(WINDOW);
	localparam int ADR_BITS = BIN_BITS + WIN_BITS;
	localparam int SUM_W    = SAMPLE_BITS + WIN_BITS;
	localparam int SQ_W     = 2 * SAMPLE_BITS + WIN_BITS;
	localparam int HC_W     = 7;

	// Stream and register port widths.
	localparam int BIN_W    = 8;
	localparam int MAG_W    = 16;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 32;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 12;

	// Register indexes.
	localparam logic [CFG_AW-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_AW-1:0] REG_ALPHA     = 3'd1;
	localparam logic [CFG_AW-1:0] REG_MEAN_GAIN = 3'd2;
	localparam logic [CFG_AW-1:0] REG_VAR_GAIN  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_HIT_HOLD  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_HIT_STEP  = 3'd5;

	// Level modes.
	localparam logic [1:0] MODE_EXP  = 2'd0;
	localparam logic [1:0] MODE_MEAN = 2'd1;
	localparam logic [1:0] MODE_VAR  = 2'd2;

	localparam logic [8:0] ALPHA_ONE = 9'd256;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SQ,
		ST_ACC,
		ST_MUL1,
		ST_MUL2,
		ST_FIN
	} sbs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic sq;
		logic acc;
		logic mul1;
		logic mul2;
		logic fin;
	} sbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bin_ok;
		logic clr_done;
		logic out_busy;
	} sbs_sts_t;

	// One row of per-bin state.
	typedef struct packed {
		logic [HC_W-1:0]        hc;
		logic [SAMPLE_BITS-1:0] lvl;
		logic [SQ_W-1:0]        sumsq;
		logic [SUM_W-1:0]       sum;
	} sbs_row_t;

endpackage

[rtl/core/sbs_ctrl.sv]
module sbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  sbs_pkg::sbs_sts_t sts,
	output sbs_pkg::sbs_cmd_t cmd
);

	sbs_pkg::sbs_state_t state_q;
	sbs_pkg::sbs_state_t state_nxt;
	logic                in_xfer;

	assign s_axis_tready = (state_q == sbs_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sbs_pkg::ST_CLEAR: begin
				if (sts.clr_done) state_nxt = sbs_pkg::ST_IDLE;
			end
			sbs_pkg::ST_IDLE: begin
				if (in_xfer && sts.bin_ok) state_nxt = sbs_pkg::ST_READ;
			end
			sbs_pkg::ST_READ: state_nxt = sbs_pkg::ST_SQ;
			sbs_pkg::ST_SQ:   state_nxt = sbs_pkg::ST_ACC;
			sbs_pkg::ST_ACC:  state_nxt = sbs_pkg::ST_MUL1;
			sbs_pkg::ST_MUL1: state_nxt = sbs_pkg::ST_MUL2;
			sbs_pkg::ST_MUL2: state_nxt = sbs_pkg::ST_FIN;
			sbs_pkg::ST_FIN: begin
				if (!sts.out_busy) state_nxt = sbs_pkg::ST_IDLE;
			end
			default: state_nxt = sbs_pkg::ST_CLEAR;
		endcase
	end

	// Commands.
	always_comb begin
		cmd      = '0;
		cmd.load = in_xfer;
		unique case (state_q)
			sbs_pkg::ST_CLEAR: cmd.clr  = 1'b1;
			sbs_pkg::ST_READ:  cmd.rd   = 1'b1;
			sbs_pkg::ST_SQ:    cmd.sq   = 1'b1;
			sbs_pkg::ST_ACC:   cmd.acc  = 1'b1;
			sbs_pkg::ST_MUL1:  cmd.mul1 = 1'b1;
			sbs_pkg::ST_MUL2:  cmd.mul2 = 1'b1;
			sbs_pkg::ST_FIN:   cmd.fin  = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

[rtl/core/sbs_datapath.sv]
module sbs_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sbs_pkg::IN_W-1:0]    s_axis_tdata,
	input  logic                        cfg_valid,
	input  logic [sbs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [sbs_pkg::CFG_DW-1:0]  cfg_data,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [sbs_pkg::OUT_W-1:0]   m_axis_tdata,
	input  sbs_pkg::sbs_cmd_t           cmd,
	output sbs_pkg::sbs_sts_t           sts
);

	localparam int S   = sbs_pkg::SAMPLE_BITS;
	localparam int MGP = sbs_pkg::SUM_W + 10;
	localparam int VGP = 2 * S + 12;

	localparam logic [8:0] ALPHA_ONE_C = sbs_pkg::ALPHA_ONE;

	// Configuration registers.
	logic [1:0]  mode_q;
	logic [8:0]  alpha_q;
	logic [9:0]  mean_gain_q;
	logic [11:0] var_gain_q;
	logic [6:0]  hit_hold_q;
	logic [6:0]  hit_step_q;

	// Memories.
	logic [S-1:0]     win_mem [sbs_pkg::BINS * sbs_pkg::WINDOW];
	sbs_pkg::sbs_row_t bin_mem [sbs_pkg::BINS];

	logic [sbs_pkg::ADR_BITS-1:0] clr_cnt_q;
	logic [sbs_pkg::WIN_BITS-1:0] ptr_q;
	logic [sbs_pkg::BIN_W-1:0]    bin_q;
	logic [S-1:0]                 x_q;
	logic [S-1:0]                 old_q;
	sbs_pkg::sbs_row_t            row_q;
	logic [2*S-1:0]               xx_q;
	logic [2*S-1:0]               oo_q;
	logic [sbs_pkg::SUM_W-1:0]    sum_q;
	logic [sbs_pkg::SQ_W-1:0]     sumsq_q;
	logic [S+8:0]                 ax_q;
	logic [S+8:0]                 bl_q;
	logic [MGP-1:0]               mg_q;
	logic [2*S-1:0]               mm_q;
	logic [2*S-1:0]               qv_q;
	logic [S-1:0]                 lvl_q;
	logic                         out_valid_q;
	logic [sbs_pkg::OUT_W-1:0]    out_data_q;

	logic [sbs_pkg::BIN_BITS-1:0] bin_adr;
	logic [sbs_pkg::ADR_BITS-1:0] win_adr;
	logic [8:0]                   alpha_c;
	logic [S+9:0]                 exp_sum;
	logic [2*S-1:0]               var_v;
	logic [VGP-1:0]               var_p;
	logic [MGP-1:0]               mean_t;
	logic [VGP-1:0]               var_t;
	logic [S-1:0]                 lvl_nxt;
	logic                         above;
	logic [6:0]                   hc_nxt;
	sbs_pkg::sbs_row_t            row_new;

	assign bin_adr = bin_q[sbs_pkg::BIN_BITS-1:0];
	assign win_adr = {bin_adr, ptr_q};

	assign sts.bin_ok   = (int'(s_axis_tdata[sbs_pkg::BIN_W-1:0]) < sbs_pkg::BINS);
	assign sts.clr_done = (clr_cnt_q == '1);
	assign sts.out_busy = out_valid_q && !m_axis_tready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sbs_pkg::MODE_EXP;
			alpha_q     <= 9'd179;
			mean_gain_q <= 10'd500;
			var_gain_q  <= 12'd1000;
			hit_hold_q  <= 7'd100;
			hit_step_q  <= 7'd10;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				sbs_pkg::REG_MODE:      mode_q      <= cfg_data[1:0];
				sbs_pkg::REG_ALPHA:     alpha_q     <= cfg_data[8:0];
				sbs_pkg::REG_MEAN_GAIN: mean_gain_q <= cfg_data[9:0];
				sbs_pkg::REG_VAR_GAIN:  var_gain_q  <= cfg_data;
				sbs_pkg::REG_HIT_HOLD:  hit_hold_q  <= cfg_data[6:0];
				sbs_pkg::REG_HIT_STEP:  hit_step_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Clearing counter and the shared window pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			ptr_q     <= '0;
		end else begin
			if (cmd.clr && !sts.clr_done) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.fin && int'(bin_q) == sbs_pkg::BINS - 1) begin
				if (int'(ptr_q) == sbs_pkg::WINDOW - 1) ptr_q <= '0;
				else ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Window memory: cleared after reset, read then rewritten once per item.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			win_mem[clr_cnt_q] <= '0;
		end else if (cmd.fin) begin
			win_mem[win_adr] <= x_q;
		end
		if (cmd.rd) old_q <= win_mem[win_adr];
	end

	// Per-bin state memory.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			bin_mem[clr_cnt_q[sbs_pkg::BIN_BITS-1:0]] <= '0;
		end else if (cmd.fin) begin
			bin_mem[bin_adr] <= row_new;
		end
		if (cmd.rd) row_q <= bin_mem[bin_adr];
	end

	// Input capture and arithmetic steps.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= s_axis_tdata[sbs_pkg::BIN_W-1:0];
			x_q   <= s_axis_tdata[sbs_pkg::BIN_W +: S];
		end
		if (cmd.sq) begin
			xx_q <= x_q * x_q;
			oo_q <= old_q * old_q;
		end
		if (cmd.acc) begin
			sum_q   <= row_q.sum + sbs_pkg::SUM_W'(x_q) - sbs_pkg::SUM_W'(old_q);
			sumsq_q <= row_q.sumsq + sbs_pkg::SQ_W'(xx_q) - sbs_pkg::SQ_W'(oo_q);
			ax_q    <= alpha_c * x_q;
			bl_q    <= (ALPHA_ONE_C - alpha_c) * row_q.lvl;
		end
		if (cmd.mul1) begin
			mg_q <= sum_q * mean_gain_q;
			mm_q <= sum_q[sbs_pkg::SUM_W-1:sbs_pkg::WIN_BITS]
				* sum_q[sbs_pkg::SUM_W-1:sbs_pkg::WIN_BITS];
			qv_q <= sumsq_q[sbs_pkg::SQ_W-1:sbs_pkg::WIN_BITS];
		end
		if (cmd.mul2) lvl_q <= lvl_nxt;
	end

	// Weights above one act as one.
	assign alpha_c = (alpha_q > ALPHA_ONE_C) ? ALPHA_ONE_C : alpha_q;

	// New level selected by mode.
	always_comb begin
		exp_sum = (S+10)'(ax_q) + (S+10)'(bl_q) + (S+10)'(128);
		mean_t  = mg_q >> sbs_pkg::WIN_BITS;
		var_v   = qv_q - mm_q;
		var_p   = var_v * var_gain_q;
		var_t   = var_p >> S;
		unique case (mode_q)
			sbs_pkg::MODE_EXP:  lvl_nxt = exp_sum[S+7:8];
			sbs_pkg::MODE_MEAN: lvl_nxt = (mean_t > MGP'({S{1'b1}})) ? '1 : mean_t[S-1:0];
			sbs_pkg::MODE_VAR:  lvl_nxt = (var_t > VGP'({S{1'b1}})) ? '1 : var_t[S-1:0];
			default:            lvl_nxt = row_q.lvl;
		endcase
	end

	// Hit counter and the row written back.
	always_comb begin
		above = x_q > lvl_q;
		if (above) hc_nxt = hit_hold_q;
		else if (row_q.hc > hit_step_q) hc_nxt = row_q.hc - hit_step_q;
		else hc_nxt = row_q.hc;
		row_new.sum   = sum_q;
		row_new.sumsq = sumsq_q;
		row_new.lvl   = lvl_q;
		row_new.hc    = hc_nxt;
	end

	// Output register: a result waits here until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) out_data_q <= {above, hc_nxt, lvl_q, bin_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[rtl/core/spectrum_bin_smoother_core.sv]
// After an input item is taken, the controller steps through READ, SQ, ACC,
// MUL1, MUL2 and FIN over the single-port window and bin memories; the result
// is registered at FIN, which waits while the output is stalled. No new item
// is taken until FIN is done. Reset: asynchronous, active low; registers take
// their reset values, then a clearing pass zeroes the memories before any input.
module spectrum_bin_smoother_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// bin_index [7:0], magnitude [23:8]
	input  logic [sbs_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// bin_out [7:0], level [23:8], hit_level [30:24], above [31]
	output logic [sbs_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sbs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [sbs_pkg::CFG_DW-1:0]  cfg_data
);

	sbs_pkg::sbs_cmd_t cmd;
	sbs_pkg::sbs_sts_t sts;

	// Registers accept a transfer in every cycle.
	assign cfg_ready = 1'b1;

	sbs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	sbs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

[test/tb_spectrum_bin_smoother_core.sv]
`timescale 1ns / 100ps

module tb_spectrum_bin_smoother_core;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20;

	// Indexes past the last register.
	localparam logic [sbs_pkg::CFG_AW-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [sbs_pkg::CFG_AW-1:0] REG_SPARE_LO = 3'd6;

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [sbs_pkg::IN_W-1:0]     s_axis_tdata;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [sbs_pkg::OUT_W-1:0]    m_axis_tdata;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [sbs_pkg::CFG_AW-1:0]   cfg_addr;
	logic [sbs_pkg::CFG_DW-1:0]   cfg_data;

	// Shadow of the block's registers and per-bin state.
	logic [1:0]          cur_mode;
	logic [8:0]          cur_alpha;
	logic [9:0]          cur_mean_gain;
	logic [11:0]         cur_var_gain;
	logic [6:0]          cur_hit_hold;
	logic [6:0]          cur_hit_step;
	logic [15:0]         win_mem [sbs_pkg::BINS*sbs_pkg::WINDOW];
	longint unsigned     sum_of [sbs_pkg::BINS];
	longint unsigned     sumsq_of [sbs_pkg::BINS];
	logic [15:0]         level_of [sbs_pkg::BINS];
	logic [6:0]          hits_of [sbs_pkg::BINS];
	int unsigned         win_ptr;

	logic [sbs_pkg::OUT_W-1:0] pending_results [$];
	int                  sender_idle_pct;
	int                  stall_pct;
	int                  errors;
	int                  items_sent;
	int                  results_seen;
	int                  frames_done;
	int unsigned         cycles;

	spectrum_bin_smoother_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Works out the result word for one bin sample and updates the shadow state.
	function automatic logic [sbs_pkg::OUT_W-1:0] smooth_bin(input logic [7:0] b,
		input logic [15:0] x);
		int unsigned     slot;
		longint unsigned old_s, xs, lvl, a, m, q, v;
		logic            hit;
		logic [6:0]      hc;
		slot = b * sbs_pkg::WINDOW + win_ptr;
		old_s = win_mem[slot];
		xs = x;
		win_mem[slot] = x;
		sum_of[b] = sum_of[b] + xs - old_s;
		sumsq_of[b] = sumsq_of[b] + xs * xs - old_s * old_s;
		lvl = level_of[b];
		case (cur_mode)
			sbs_pkg::MODE_EXP: begin
				a = (cur_alpha > sbs_pkg::ALPHA_ONE) ? 256 : cur_alpha;
				lvl = (a * xs + (256 - a) * lvl + 128) >> 8;
			end
			sbs_pkg::MODE_MEAN: begin
				lvl = sum_of[b] * cur_mean_gain / sbs_pkg::WINDOW;
				if (lvl > 65535) lvl = 65535;
			end
			sbs_pkg::MODE_VAR: begin
				m = sum_of[b] / sbs_pkg::WINDOW;
				q = sumsq_of[b] / sbs_pkg::WINDOW;
				v = q - m * m;
				lvl = (v * cur_var_gain) >> sbs_pkg::SAMPLE_BITS;
				if (lvl > 65535) lvl = 65535;
			end
			default: begin
				// The unused mode keeps the level as it was.
			end
		endcase
		level_of[b] = lvl[15:0];
		hit = xs > lvl;
		hc = hits_of[b];
		if (hit) hc = cur_hit_hold;
		else if (hc > cur_hit_step) hc = hc - cur_hit_step;
		hits_of[b] = hc;
		if (b == sbs_pkg::BINS - 1) begin
			win_ptr = (win_ptr + 1) % sbs_pkg::WINDOW;
			frames_done++;
		end
		return {hit, hc, lvl[15:0], b};
	endfunction

	task automatic report_mismatch(input string field, input int exp_v, input int got_v);
		$display("mismatch in %s: expected %0d, got %0d at cycle %0d",
			field, exp_v, got_v, cycles);
		errors++;
	endtask

	// Sends one bin sample; called at a rising edge, returns at the edge of its transfer.
	task automatic send_bin(input logic [7:0] b, input logic [15:0] x);
		logic [sbs_pkg::OUT_W-1:0] want;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {x, b};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		want = smooth_bin(b, x);
		pending_results = {pending_results, want};
		items_sent++;
	endtask

	// Lowers valid and waits until every expected result has been seen.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register transfer, with valid lowered again on the register channel afterwards.
	task automatic write_reg(input logic [sbs_pkg::CFG_AW-1:0] idx,
		input logic [sbs_pkg::CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			sbs_pkg::REG_MODE:      cur_mode = val[1:0];
			sbs_pkg::REG_ALPHA:     cur_alpha = val[8:0];
			sbs_pkg::REG_MEAN_GAIN: cur_mean_gain = val[9:0];
			sbs_pkg::REG_VAR_GAIN:  cur_var_gain = val[11:0];
			sbs_pkg::REG_HIT_HOLD:  cur_hit_hold = val[6:0];
			sbs_pkg::REG_HIT_STEP:  cur_hit_step = val[6:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_all(input logic [1:0] md, input int al, input int mg, input int vg,
		input int hh, input int hs);
		drain();
		write_reg(sbs_pkg::REG_MODE, sbs_pkg::CFG_DW'(md));
		write_reg(sbs_pkg::REG_ALPHA, sbs_pkg::CFG_DW'(al));
		write_reg(sbs_pkg::REG_MEAN_GAIN, sbs_pkg::CFG_DW'(mg));
		write_reg(sbs_pkg::REG_VAR_GAIN, sbs_pkg::CFG_DW'(vg));
		write_reg(sbs_pkg::REG_HIT_HOLD, sbs_pkg::CFG_DW'(hh));
		write_reg(sbs_pkg::REG_HIT_STEP, sbs_pkg::CFG_DW'(hs));
	endtask

	function automatic logic [15:0] pick_magnitude();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(16'h8000 + $urandom_range(255));
			default: return 16'($urandom());
		endcase
	endfunction

	// Directed corners at the reset settings, including a repeated bin and frame ends.
	task automatic test_directed;
		send_bin(8'd0, 16'h0000);
		send_bin(8'd0, 16'hFFFF);
		send_bin(8'd0, 16'hFFFF);
		send_bin(8'd1, 16'hAAAA);
		send_bin(8'd1, 16'h5555);
		send_bin(8'd255, 16'hFFFF);
		send_bin(8'd128, 16'h0001);
		send_bin(8'd255, 16'h0000);
		send_bin(8'd1, 16'h0000);
		send_bin(8'd1, 16'h0000);
		drain();
	endtask

	// Every mode, including the unused one, with alpha above one and register extremes.
	task automatic test_modes;
		int md;
		int k;
		for (md = 0; md < 4; md++) begin
			set_all(2'(md), (md == 0) ? 511 : 256, 1023, 4095, 127, 0);
			for (k = 0; k < 4; k++) send_bin(k[0] ? 8'd255 : 8'd2, k[1] ? 16'hFFFF : 16'h0000);
		end
		drain();
		// An index past the last register must leave everything alone.
		write_reg(REG_SPARE_HI, 12'hFFF);
		write_reg(REG_SPARE_LO, 12'h000);
		send_bin(8'd2, 16'h1234);
		drain();
	endtask

	// Frames of a few low bins closed by the last bin, with some noise bins mixed in.
	task automatic test_random_frames(input int n, input int idle, input int stall);
		int left;
		int len;
		sender_idle_pct = idle;
		stall_pct = stall;
		left = n;
		while (left > 0) begin
			len = $urandom_range(6);
			repeat (len) begin
				if ($urandom_range(9) == 0) send_bin(8'($urandom_range(255)), pick_magnitude());
				else send_bin(8'($urandom_range(7)), pick_magnitude());
				left--;
			end
			send_bin(8'd255, pick_magnitude());
			left--;
			if (left > 0 && left < 8) begin
				// Hold off until the block has delivered all that it owes.
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
		end
	endtask

	// Free-running receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compares each result transfer with the oldest pending result.
	always @(negedge clk) begin
		logic [sbs_pkg::OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 0, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (want[7:0] != m_axis_tdata[7:0])
					report_mismatch("bin_out", want[7:0], m_axis_tdata[7:0]);
				if (want[23:8] != m_axis_tdata[23:8])
					report_mismatch("level", want[23:8], m_axis_tdata[23:8]);
				if (want[30:24] != m_axis_tdata[30:24])
					report_mismatch("hit_level", want[30:24], m_axis_tdata[30:24]);
				if (want[31] != m_axis_tdata[31])
					report_mismatch("above", want[31], m_axis_tdata[31]);
			end
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results pending", pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		cycles = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		frames_done = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		win_ptr = 0;
		cur_mode = sbs_pkg::MODE_EXP;
		cur_alpha = 9'd179;
		cur_mean_gain = 10'd500;
		cur_var_gain = 12'd1000;
		cur_hit_hold = 7'd100;
		cur_hit_step = 7'd10;
		for (i = 0; i < sbs_pkg::BINS * sbs_pkg::WINDOW; i++) win_mem[i] = '0;
		for (i = 0; i < sbs_pkg::BINS; i++) begin
			sum_of[i] = 0;
			sumsq_of[i] = 0;
			level_of[i] = '0;
			hits_of[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_modes();
		set_all(sbs_pkg::MODE_VAR, 0, 0, 4095, 127, 127);
		test_random_frames(460, 0, 0);
		set_all(sbs_pkg::MODE_MEAN, 300, 1023, 1, 0, 1);
		test_random_frames(460, 53, 0);
		set_all(sbs_pkg::MODE_EXP, 0, 2, 2048, 64, 127);
		test_random_frames(460, 0, 53);
		set_all(sbs_pkg::MODE_VAR, 128, 700, 4095, 127, 5);
		test_random_frames(470, 32, 32);
		drain();

		$display("covered %0d items in %0d frames over four modes and four idling phases",
			items_sent, frames_done);
		$display("%0d results checked, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[spectrum_bin_smoother_core.f]
rtl/core/sbs_pkg.sv
rtl/core/sbs_ctrl.sv
rtl/core/sbs_datapath.sv
rtl/core/spectrum_bin_smoother_core.sv
test/tb_spectrum_bin_smoother_core.sv
